/* hw/rtl/brf_pkg.sv */
`default_nettype none

package brf_pkg;

   // register and field widths
   localparam int CAP_W     = 10;
   localparam int COUNT_W   = 10;
   localparam int LEVEL_W   = 10;
   localparam int DATA_W    = 64;
   localparam int LANES     = 8;
   localparam int LANE_W    = 3;
   localparam int MAX_SLOTS = 1 << CAP_W;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

   // request operations
   typedef enum logic [1:0] {
      MODE_PUSH     = 2'd0,
      MODE_POP      = 2'd1,
      MODE_DROP_NEW = 2'd2,
      MODE_DROP_OLD = 2'd3
   } brf_mode_type;

   // one finished response
   typedef struct packed {
      logic [LEVEL_W-1:0] free_level;
      logic [LEVEL_W-1:0] used_level;
      logic [DATA_W-1:0]  data_out;
      logic [LEVEL_W-1:0] moved;
   } brf_result_type;

endpackage

`default_nettype wire

/* hw/rtl/brf_byte_ram.sv */
`default_nettype none

module brf_byte_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // byte write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered byte read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/brf_engine.sv */
`default_nettype none

module brf_engine
   import brf_pkg::*;
#(
   parameter int BURST_BYTES = 8,
   parameter int IDX_W       = 10,
   parameter int CNT_W       = 11
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cfg_clear,
   input  wire logic [CNT_W-1:0]   slots,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire brf_mode_type       req_mode,
   input  wire logic [COUNT_W-1:0] req_count,
   input  wire logic               req_force,
   input  wire logic [DATA_W-1:0]  req_data,
   input  wire logic               out_free,
   output logic                    res_load,
   output brf_result_type          res,
   output logic                    ram_wr_en,
   output logic [IDX_W-1:0]        ram_wr_addr,
   output logic [7:0]              ram_wr_data,
   output logic                    ram_rd_en,
   output logic [IDX_W-1:0]        ram_rd_addr,
   input  wire logic [7:0]         ram_rd_data
);

   localparam int CMP_W   = CAP_W + 1;
   localparam int BURST_W = $clog2(BURST_BYTES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_DECIDE,
      ST_PUSH,
      ST_POP,
      ST_DROP,
      ST_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   brf_mode_type               mode_ff, mode_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       force_ff, force_in;
   logic [DATA_W-1:0]          data_ff, data_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]           wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]           used_ff, used_in;
   logic [CNT_W-1:0]           room_ff, room_in;
   logic [LEVEL_W-1:0]         moved_ff, moved_in;
   logic [BURST_W-1:0]         left_ff, left_in;
   logic [IDX_W-1:0]           drop_n_ff, drop_n_in;
   logic                       pend_ff, pend_in;
   logic [LANE_W-1:0]          pos_ff, pos_in;
   logic [LANES-1:0][7:0]      bytes_ff, bytes_in;

   logic [CNT_W-1:0] used_c;
   logic [CNT_W-1:0] room_c;
   logic [IDX_W-1:0] step_src;
   logic [CNT_W-1:0] step_sum;
   logic [IDX_W-1:0] step_next;
   logic [CMP_W-1:0] cnt_x, used_x, room_x;
   logic [CMP_W-1:0] n_push, n_pop;
   logic             ok_push, ok_pop, burst_ok;
   logic [CNT_W-1:0] drop_sum;

   // fill level from the two pointers, shared by the level and finish steps
   assign used_c = (wr_idx_ff >= rd_idx_ff)
                 ? CNT_W'(wr_idx_ff) - CNT_W'(rd_idx_ff)
                 : slots + CNT_W'(wr_idx_ff) - CNT_W'(rd_idx_ff);
   assign room_c = slots - CNT_W'(1) - used_c;

   // single pointer incrementer with wrap at the slot count
   assign step_src  = (state_ff == ST_POP) ? rd_idx_ff : wr_idx_ff;
   assign step_sum  = CNT_W'(step_src) + CNT_W'(1);
   assign step_next = (step_sum == slots) ? '0 : IDX_W'(step_sum);

   // burst decision against the registered levels
   assign cnt_x    = CMP_W'(count_ff);
   assign used_x   = CMP_W'(used_ff);
   assign room_x   = CMP_W'(room_ff);
   assign burst_ok = cnt_x <= CMP_W'(BURST_BYTES);
   assign n_push   = (cnt_x < room_x) ? cnt_x : room_x;
   assign n_pop    = (cnt_x < used_x) ? cnt_x : used_x;
   assign ok_push  = burst_ok && (n_push != '0) && (force_ff || room_x >= cnt_x);
   assign ok_pop   = burst_ok && (n_pop != '0) && (force_ff || used_x >= cnt_x);

   assign drop_sum = CNT_W'(rd_idx_ff) + CNT_W'(drop_n_ff);

   // memory port drive
   assign ram_wr_addr = wr_idx_ff;
   assign ram_wr_data = data_ff[7:0];
   assign ram_rd_addr = rd_idx_ff;

   assign req_ready = (state_ff == ST_IDLE);

   // response fields
   assign res.moved      = moved_ff;
   assign res.data_out   = bytes_ff;
   assign res.used_level = LEVEL_W'(used_c);
   assign res.free_level = LEVEL_W'(room_c);

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      count_in  = count_ff;
      force_in  = force_ff;
      data_in   = data_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      used_in   = used_ff;
      room_in   = room_ff;
      moved_in  = moved_ff;
      left_in   = left_ff;
      drop_n_in = drop_n_ff;
      pend_in   = 1'b0;
      pos_in    = pos_ff;
      bytes_in  = bytes_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      res_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cfg_clear) begin
               rd_idx_in = '0;
               wr_idx_in = '0;
            end
            if (req_valid) begin
               mode_in  = req_mode;
               count_in = req_count;
               force_in = req_force;
               data_in  = req_data;
               moved_in = '0;
               pos_in   = '0;
               bytes_in = '0;
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            used_in  = used_c;
            room_in  = room_c;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            case (mode_ff)
               MODE_PUSH: begin
                  if (ok_push) begin
                     moved_in = LEVEL_W'(n_push);
                     left_in  = BURST_W'(n_push);
                     state_in = ST_PUSH;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               MODE_POP: begin
                  if (ok_pop) begin
                     moved_in = LEVEL_W'(n_pop);
                     left_in  = BURST_W'(n_pop);
                     state_in = ST_POP;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               default: begin
                  // both drops are capped at the fill level
                  moved_in  = LEVEL_W'(n_pop);
                  drop_n_in = IDX_W'(n_pop);
                  state_in  = ST_DROP;
               end
            endcase
         end
         ST_PUSH: begin
            ram_wr_en = 1'b1;
            wr_idx_in = step_next;
            data_in   = data_ff >> 8;
            left_in   = left_ff - BURST_W'(1);
            if (left_ff == BURST_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_POP: begin
            // reads issue one per cycle, data lands in the next cycle
            if (left_ff != '0) begin
               ram_rd_en = 1'b1;
               rd_idx_in = step_next;
               left_in   = left_ff - BURST_W'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               bytes_in[pos_ff] = ram_rd_data;
               pos_in           = pos_ff + LANE_W'(1);
               if (left_ff == '0) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DROP: begin
            if (mode_ff == MODE_DROP_NEW) begin
               if (wr_idx_ff >= drop_n_ff) begin
                  wr_idx_in = wr_idx_ff - drop_n_ff;
               end else begin
                  wr_idx_in = IDX_W'(CNT_W'(wr_idx_ff) + slots - CNT_W'(drop_n_ff));
               end
            end else begin
               rd_idx_in = (drop_sum >= slots) ? IDX_W'(drop_sum - slots)
                                               : IDX_W'(drop_sum);
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         pend_ff   <= pend_in;
      end
      mode_ff   <= mode_in;
      count_ff  <= count_in;
      force_ff  <= force_in;
      data_ff   <= data_in;
      used_ff   <= used_in;
      room_ff   <= room_in;
      moved_ff  <= moved_in;
      left_ff   <= left_in;
      drop_n_ff <= drop_n_in;
      pos_ff    <= pos_in;
      bytes_ff  <= bytes_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/byte_ring_fifo_burst_core.sv */
`default_nettype none

// Byte ring FIFO with burst push and pop. Each request on req_ carries one
// operation (push, pop, drop newest, drop oldest) and gets exactly one
// response on rsp_ with the bytes moved, popped data and the fill and room
// levels after it. The ring is a byte-wide memory with one write and one read
// port, so a request is handled one at a time and its bytes are moved one by
// one: the sequencer reads the levels, decides the move, then writes, reads
// through the registered read port or drops the bytes, and finishes. A
// finished response waits in an output register, so the next request is
// accepted while it is still held. Writing the capacity register empties
// the ring; it must only be written while no request is in flight. No
// clearing pass is needed after reset.
module byte_ring_fifo_burst_core
   import brf_pkg::*;
#(
   parameter int RING_SLOTS  = 1024,
   parameter int BURST_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: count[9:0], data_in[73:10], zero fill [79:74]
   input  wire logic [79:0] req_tdata,
   // tuser: mode[1:0], force_req[2]
   input  wire logic [2:0]  req_tuser,
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: moved[9:0], data_out[73:10], used_level[83:74],
   //        free_level[93:84], zero fill [95:94]
   output logic [95:0]      rsp_tdata,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int SLOT_CAP = (RING_SLOTS < MAX_SLOTS) ? RING_SLOTS : MAX_SLOTS;
   localparam int IDX_W    = $clog2(SLOT_CAP);
   localparam int CNT_W    = IDX_W + 1;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] slots_ff, slots_in;
   logic [CAP_W:0]   cap_plus;
   logic             cfg_wr;

   logic             out_valid_ff, out_valid_in;
   brf_result_type   out_ff, out_in;
   brf_result_type   res;
   logic             res_load;
   logic             out_free;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [7:0]       ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [7:0]       ram_rd_data;

   // register port: single register, every address hits it
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = 32'(capacity_ff);

   // slot count saturates at the memory depth
   assign cap_plus    = {1'b0, csr_pwdata[CAP_W-1:0]} + (CAP_W + 1)'(1);
   assign capacity_in = cfg_wr ? csr_pwdata[CAP_W-1:0] : capacity_ff;
   assign slots_in    = !cfg_wr ? slots_ff
                      : (cap_plus > (CAP_W + 1)'(SLOT_CAP)) ? CNT_W'(SLOT_CAP)
                      : CNT_W'(cap_plus);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         slots_ff    <= CNT_W'(SLOT_CAP);
      end else begin
         capacity_ff <= capacity_in;
         slots_ff    <= slots_in;
      end
   end

   // output register between sequencer and response channel
   assign out_free     = !out_valid_ff || rsp_tready;
   assign out_valid_in = res_load || (out_valid_ff && !rsp_tready);
   assign out_in       = res_load ? res : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff};

   brf_engine #(
      .BURST_BYTES (BURST_BYTES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg_clear   (cfg_wr),
      .slots       (slots_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_mode    (brf_mode_type'(req_tuser[1:0])),
      .req_count   (req_tdata[9:0]),
      .req_force   (req_tuser[2]),
      .req_data    (req_tdata[73:10]),
      .out_free    (out_free),
      .res_load    (res_load),
      .res         (res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   brf_byte_ram #(
      .DEPTH  (SLOT_CAP),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // held and free bytes always add up to the usable slots
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         (CNT_W + 1)'(out_ff.used_level) + (CNT_W + 1)'(out_ff.free_level)
         == (CNT_W + 1)'(slots_ff) - (CNT_W + 1)'(1))
      else $error("used and free levels do not match the slot count");

   // one request at a time: accepting one drops ready in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while the previous one is in flight");

   // popped data only comes with a nonzero move count
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.data_out != '0) |-> out_ff.moved != '0)
      else $error("response data without moved bytes");

endmodule

`default_nettype wire
